@@ rtl/priority_ready_queue_defines.svh @@
// Assertion macros for the priority ready queue.
`ifndef PRIORITY_READY_QUEUE_DEFINES_SVH
`define PRIORITY_READY_QUEUE_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a same-cycle implication, disabled in reset.
`define PRQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check an implication in the next cycle, disabled in reset.
`define PRQ_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define PRQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define PRQ_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

@@ rtl/prq_pkg.sv @@
// Shared constants, types and status codes of the priority ready queue.
`timescale 1ns / 1ps
`default_nettype none

package prq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_BITS    = 16;

  // Widths of the port fields.
  localparam int TAG_PORT_W  = 16;
  localparam int PRIO_W      = 4;
  localparam int STATUS_W    = 3;
  localparam int OCC_W       = 5;

  // Stored tag width: the port already limits a tag to its own width.
  localparam int STORE_TAG_W = (TAG_BITS < TAG_PORT_W) ? TAG_BITS : TAG_PORT_W;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [PRIO_W-1:0] PRIO_MIN = PRIO_W'(1);
  localparam logic [PRIO_W-1:0] PRIO_MAX = PRIO_W'(10);

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ENQ   = 3'd0,
    ST_DUP   = 3'd1,
    ST_FULL  = 3'd2,
    ST_DEQ   = 3'd3,
    ST_EMPTY = 3'd4
  } status_t;

  typedef struct packed {
    logic [STORE_TAG_W-1:0] tag;
    logic [PRIO_W-1:0]      prio;
  } ent_t;

  typedef struct packed {
    logic func;
    ent_t ent;
  } req_t;

  typedef struct packed {
    status_t    status;
    ent_t       ent;
    logic [CNT_W-1:0] occ;
  } res_t;

  typedef struct packed {
    logic tag_eq;
    logic prio_lt;
  } cmp_t;

endpackage

`default_nettype wire

@@ rtl/priority_ready_queue.sv @@
// Top level of the priority ready queue: input capture, output register, checks.
//
//   channel   signals                          transfer when
//   input     func, proc_tag, prio             in_valid  & in_ready
//   output    status, out_tag, out_prio,       out_valid & out_ready
//             occupancy
//
// An enqueue scans every queued entry, then shifts those behind the insert point
// one place toward the tail; a duplicate or a full drop ends after the scan, and
// a dequeue sweeps the entries once. A result is held back while the output
// register stays full. One entry per cycle moves through the array.
// Reset clears the state, fill count and valid flags; array contents are never read unwritten.
// A result waits in the output register while the next item is taken.
`timescale 1ns / 1ps
`default_nettype none

`include "priority_ready_queue_defines.svh"

module priority_ready_queue (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire                                func,
  input  wire  [prq_pkg::TAG_PORT_W-1:0]     proc_tag,
  input  wire  [prq_pkg::PRIO_W-1:0]         prio,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [prq_pkg::STATUS_W-1:0]       status,
  output logic [prq_pkg::TAG_PORT_W-1:0]     out_tag,
  output logic [prq_pkg::PRIO_W-1:0]         out_prio,
  output logic [prq_pkg::OCC_W-1:0]          occupancy
);

  localparam int TW  = prq_pkg::TAG_PORT_W;
  localparam int CW  = prq_pkg::CNT_W;
  localparam int OW  = prq_pkg::OCC_W;
  localparam int XW  = CW + OW;

  logic             start;
  logic             seq_idle;
  logic             res_valid;
  logic             res_ready;
  prq_pkg::req_t    req;
  prq_pkg::res_t    res;
  logic [prq_pkg::PRIO_W-1:0] prio_clamp;
  logic [XW-1:0]    occ_wide;

  // Clamp priority into its legal range.
  always_comb begin
    priority if (prio < prq_pkg::PRIO_MIN) begin
      prio_clamp = prq_pkg::PRIO_MIN;
    end else if (prio > prq_pkg::PRIO_MAX) begin
      prio_clamp = prq_pkg::PRIO_MAX;
    end else begin
      prio_clamp = prio;
    end
  end

  assign req.func     = func;
  assign req.ent.tag  = proc_tag[prq_pkg::STORE_TAG_W-1:0];
  assign req.ent.prio = prio_clamp;

  assign in_ready  = seq_idle;
  assign start     = in_valid && in_ready;
  assign res_ready = !out_valid || out_ready;

  prq_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .idle      (seq_idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign occ_wide = XW'(res.occ);

  // Load the output register on a handoff, drop it on a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        out_valid <= 1'b1;
        status    <= res.status;
        out_tag   <= TW'(res.ent.tag);
        out_prio  <= res.ent.prio;
        occupancy <= occ_wide[OW-1:0];
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Checks.
  `PRQ_ASSERT_IMP(a_occ_bound, clk, rst, res_valid, res.occ <= CW'(prq_pkg::QUEUE_DEPTH), "occupancy above queue depth")
  `PRQ_ASSERT_IMP(a_deq_prio, clk, rst, out_valid && (status == prq_pkg::ST_DEQ), (out_prio >= prq_pkg::PRIO_MIN) && (out_prio <= prq_pkg::PRIO_MAX), "dequeued priority out of range")
  `PRQ_ASSERT_IMP(a_zero_fields, clk, rst, out_valid && (status != prq_pkg::ST_DEQ), (out_tag == '0) && (out_prio == '0), "tag or priority nonzero without dequeue")
  `PRQ_ASSERT_NXT(a_no_instant, clk, rst, start, !res_valid && !seq_idle, "result posted in the cycle after transfer")

endmodule

`default_nettype wire

@@ rtl/prq_cmp.sv @@
// Shared compare unit: matches a stored entry against the request key.
`timescale 1ns / 1ps
`default_nettype none

module prq_cmp (
  input  prq_pkg::ent_t ent,
  input  prq_pkg::ent_t key,
  output prq_pkg::cmp_t flags
);

  // Tag match flags a duplicate, lower stored priority marks the insert point.
  assign flags.tag_eq  = (ent.tag == key.tag);
  assign flags.prio_lt = (ent.prio < key.prio);

endmodule

`default_nettype wire

@@ rtl/prq_seq.sv @@
// Sequencer and entry array: scans, shifts and updates the sorted list.
`timescale 1ns / 1ps
`default_nettype none

module prq_seq (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  prq_pkg::req_t       req,
  output logic                idle,
  output logic                res_valid,
  input  wire                 res_ready,
  output prq_pkg::res_t       res
);

  localparam int DEPTH = prq_pkg::QUEUE_DEPTH;
  localparam int IW    = prq_pkg::IDX_W;
  localparam int CW    = prq_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DEQ,
    S_DONE
  } state_t;

  state_t        state;
  logic [CW-1:0] fill;
  logic [CW-1:0] idx;
  logic [CW-1:0] idx_dec;
  logic [CW-1:0] pos;
  logic [IW-1:0] pidx;
  logic          pv;
  logic          dup;
  logic          found;
  prq_pkg::ent_t key;
  prq_pkg::ent_t head;

  // Entry array with one write and one registered read per cycle.
  prq_pkg::ent_t mem [DEPTH];
  prq_pkg::ent_t rdata;
  logic [IW-1:0] rd_addr;
  logic          we;
  logic [IW-1:0] wa;
  prq_pkg::ent_t wd;

  prq_pkg::cmp_t flags;

  prq_cmp u_cmp (
    .ent   (rdata),
    .key   (key),
    .flags (flags)
  );

  assign idx_dec = idx - CW'(1);
  assign idle    = (state == S_IDLE);

  // Select read address and write for the current sweep step.
  always_comb begin
    rd_addr = '0;
    we      = 1'b0;
    wa      = '0;
    wd      = rdata;
    unique case (state)
      S_SCAN: begin
        rd_addr = idx[IW-1:0];
      end
      S_SHIFT: begin
        rd_addr = idx_dec[IW-1:0];
        if (pv) begin
          we = 1'b1;
          wa = pidx;
        end else if (idx == pos) begin
          we = 1'b1;
          wa = pos[IW-1:0];
          wd = key;
        end
      end
      S_DEQ: begin
        rd_addr = idx[IW-1:0];
        if (pv && (pidx != '0)) begin
          we = 1'b1;
          wa = pidx - IW'(1);
        end
      end
      S_IDLE, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Write and read the entry array.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[rd_addr];
  end

  // Sequence one request: scan and shift for an enqueue or sweep for a dequeue, then post the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      pv        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          pv <= 1'b0;
          if (start) begin
            key   <= req.ent;
            idx   <= '0;
            dup   <= 1'b0;
            found <= 1'b0;
            pos   <= '0;
            head  <= '0;
            state <= (req.func == prq_pkg::FUNC_DEQ) ? S_DEQ : S_SCAN;
          end
        end

        S_SCAN: begin
          if (idx != fill) begin
            pv   <= 1'b1;
            pidx <= idx[IW-1:0];
            idx  <= idx + CW'(1);
          end else begin
            pv <= 1'b0;
          end
          if (pv) begin
            if (flags.tag_eq) begin
              dup <= 1'b1;
            end
            if (flags.prio_lt && !found) begin
              found <= 1'b1;
              pos   <= CW'(pidx);
            end
          end
          // Decide once the last entry has been compared.
          if ((idx == fill) && !pv) begin
            if (dup) begin
              res.status <= prq_pkg::ST_DUP;
              res.ent    <= '0;
              res.occ    <= fill;
              res_valid  <= 1'b1;
              state      <= S_DONE;
            end else if (fill == CW'(DEPTH)) begin
              res.status <= prq_pkg::ST_FULL;
              res.ent    <= '0;
              res.occ    <= fill;
              res_valid  <= 1'b1;
              state      <= S_DONE;
            end else begin
              if (!found) begin
                pos <= fill;
              end
              idx   <= fill;
              state <= S_SHIFT;
            end
          end
        end

        S_SHIFT: begin
          // Move entries one place toward the tail, down to the insert point.
          if (idx != pos) begin
            pv   <= 1'b1;
            pidx <= idx[IW-1:0];
            idx  <= idx_dec;
          end else begin
            pv <= 1'b0;
          end
          if ((idx == pos) && !pv) begin
            fill       <= fill + CW'(1);
            res.status <= prq_pkg::ST_ENQ;
            res.ent    <= '0;
            res.occ    <= fill + CW'(1);
            res_valid  <= 1'b1;
            state      <= S_DONE;
          end
        end

        S_DEQ: begin
          // Take the head, then move the rest one place toward the head.
          if (idx != fill) begin
            pv   <= 1'b1;
            pidx <= idx[IW-1:0];
            idx  <= idx + CW'(1);
          end else begin
            pv <= 1'b0;
          end
          if (pv && (pidx == '0)) begin
            head <= rdata;
          end
          if ((idx == fill) && !pv) begin
            if (fill == '0) begin
              res.status <= prq_pkg::ST_EMPTY;
              res.ent    <= '0;
              res.occ    <= '0;
            end else begin
              fill       <= fill - CW'(1);
              res.status <= prq_pkg::ST_DEQ;
              res.ent    <= head;
              res.occ    <= fill - CW'(1);
            end
            res_valid <= 1'b1;
            state     <= S_DONE;
          end
        end

        S_DONE: begin
          // Hold the result until the output stage takes it.
          if (res_ready) begin
            res_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/priority_ready_queue_test.sv @@
// Self-checking testbench of the priority ready queue: directed and random traffic.
`timescale 1ns / 1ps

module priority_ready_queue_test;

  localparam int TW = prq_pkg::TAG_PORT_W;
  localparam int PW = prq_pkg::PRIO_W;
  localparam int OW = prq_pkg::OCC_W;

  localparam logic [TW-1:0] TAG_MASK = TW'((64'd1 << prq_pkg::STORE_TAG_W) - 1);

  // One result as the queue should report it
  typedef struct {
    prq_pkg::status_t status;
    logic [TW-1:0]    tag;
    logic [PW-1:0]    prio;
    logic [OW-1:0]    occ;
  } outcome_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  func = prq_pkg::FUNC_ENQ;
  logic [TW-1:0]         proc_tag = '0;
  logic [PW-1:0]         prio = '0;
  logic                  out_ready = 1'b0;
  wire                   in_ready;
  wire                   out_valid;
  wire [prq_pkg::STATUS_W-1:0] status;
  wire [TW-1:0]          out_tag;
  wire [PW-1:0]          out_prio;
  wire [OW-1:0]          occupancy;

  // Mirror of the sorted entries, head at index 0
  logic [TW-1:0]         held_tag [prq_pkg::QUEUE_DEPTH];
  logic [PW-1:0]         held_prio [prq_pkg::QUEUE_DEPTH];
  int                    held_count = 0;
  outcome_t              pending_outcomes[$];
  int                    mismatches = 0;
  int                    send_idle_pct = 29;
  int                    recv_idle_pct = 59;

  priority_ready_queue uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .proc_tag  (proc_tag),
    .prio      (prio),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .out_tag   (out_tag),
    .out_prio  (out_prio),
    .occupancy (occupancy)
  );

  always #5 clk = ~clk;

  // Apply one accepted item to the mirror and queue its outcome
  task automatic apply_to_mirror(input logic op, input logic [TW-1:0] tag_in,
                                 input logic [PW-1:0] prio_in);
    outcome_t      o;
    logic [TW-1:0] tag_m;
    logic [PW-1:0] prio_c;
    int            pos;
    int            i;
    bit            dup;
    tag_m = tag_in & TAG_MASK;
    o.tag = '0;
    o.prio = '0;
    if (op == prq_pkg::FUNC_ENQ) begin
      prio_c = (prio_in < prq_pkg::PRIO_MIN) ? prq_pkg::PRIO_MIN :
               (prio_in > prq_pkg::PRIO_MAX) ? prq_pkg::PRIO_MAX : prio_in;
      dup = 1'b0;
      for (i = 0; i < held_count; i++) begin
        if (held_tag[i] == tag_m) dup = 1'b1;
      end
      if (dup) begin
        o.status = prq_pkg::ST_DUP;
      end else if (held_count >= prq_pkg::QUEUE_DEPTH) begin
        o.status = prq_pkg::ST_FULL;
      end else begin
        // Insert behind every entry of greater or equal priority
        pos = 0;
        while (pos < held_count && held_prio[pos] >= prio_c) pos++;
        for (i = held_count; i > pos; i--) begin
          held_tag[i] = held_tag[i-1];
          held_prio[i] = held_prio[i-1];
        end
        held_tag[pos] = tag_m;
        held_prio[pos] = prio_c;
        held_count++;
        o.status = prq_pkg::ST_ENQ;
      end
    end else if (held_count == 0) begin
      o.status = prq_pkg::ST_EMPTY;
    end else begin
      // Pop the head and advance the rest
      o.tag = held_tag[0];
      o.prio = held_prio[0];
      for (i = 1; i < held_count; i++) begin
        held_tag[i-1] = held_tag[i];
        held_prio[i-1] = held_prio[i];
      end
      held_count--;
      o.status = prq_pkg::ST_DEQ;
    end
    o.occ = OW'(held_count);
    pending_outcomes.push_back(o);
  endtask

  // Offer one item, idle at random before it, and hold it until the transfer
  task automatic send_item(input logic op, input logic [TW-1:0] tag_in,
                           input logic [PW-1:0] prio_in);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= op;
    proc_tag <= tag_in;
    prio <= prio_in;
    do @(posedge clk); while (!in_ready);
    apply_to_mirror(op, tag_in, prio_in);
  endtask

  // Compare one transferred result with the oldest outcome
  task automatic check_result();
    outcome_t want;
    if (pending_outcomes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result status=%0d tag=%h prio=%0d occ=%0d",
                 $realtime, status, out_tag, out_prio, occupancy);
    end else begin
      want = pending_outcomes.pop_front();
      if (status !== want.status || out_tag !== want.tag || out_prio !== want.prio ||
          occupancy !== want.occ) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("%0t: mismatch expected status=%0d tag=%h prio=%0d occ=%0d",
                 $realtime, want.status, want.tag, want.prio, want.occ);
          $display(", got status=%0d tag=%h prio=%0d occ=%0d",
                   status, out_tag, out_prio, occupancy);
        end
      end
    end
  endtask

  // Take results and stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result();
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Pick a tag: a small pool for duplicates, a queued tag, or anything
  function automatic logic [TW-1:0] pick_tag();
    int r;
    r = $urandom_range(99);
    if (r < 40) return TW'($urandom_range(31));
    if (r < 55 && held_count > 0) return held_tag[$urandom_range(held_count - 1)];
    return TW'($urandom);
  endfunction

  // Pick a priority: mostly legal, sometimes out of range to hit the clamp
  function automatic logic [PW-1:0] pick_prio();
    if ($urandom_range(99) < 85)
      return PW'($urandom_range(prq_pkg::PRIO_MAX, prq_pkg::PRIO_MIN));
    return PW'($urandom_range(15));
  endfunction

  // Empty dequeue, priority extremes and clamps, duplicate, order of equals
  task automatic test_basic_order();
    send_item(prq_pkg::FUNC_DEQ, 16'hFFFF, 4'hF);
    send_item(prq_pkg::FUNC_ENQ, 16'h0000, 4'h0);
    send_item(prq_pkg::FUNC_ENQ, 16'hFFFF, 4'hF);
    send_item(prq_pkg::FUNC_ENQ, 16'hAAAA, 4'd10);
    send_item(prq_pkg::FUNC_ENQ, 16'h5555, 4'd1);
    send_item(prq_pkg::FUNC_ENQ, 16'h0000, 4'd7);
    send_item(prq_pkg::FUNC_ENQ, 16'h1234, 4'd5);
    send_item(prq_pkg::FUNC_DEQ, 16'h0000, 4'h0);
    send_item(prq_pkg::FUNC_DEQ, 16'h5A5A, 4'h5);
    send_item(prq_pkg::FUNC_DEQ, 16'hA5A5, 4'hA);
  endtask

  // Fill up, then drop on full and report a duplicate while full
  task automatic test_full_queue();
    int i;
    for (i = 0; held_count < prq_pkg::QUEUE_DEPTH; i++)
      send_item(prq_pkg::FUNC_ENQ, TW'(16'h0100 + i), PW'(1 + i % 10));
    send_item(prq_pkg::FUNC_ENQ, 16'hBEEF, 4'd10);
    send_item(prq_pkg::FUNC_ENQ, 16'h0105, 4'd3);
  endtask

  // Bursts that lean toward filling, draining or mixing
  task automatic run_bursts(input int count);
    int left;
    int burst;
    int enq_pct;
    int j;
    logic op;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(24, 4);
      case ($urandom_range(2))
        0: enq_pct = 85;
        1: enq_pct = 15;
        default: enq_pct = 50;
      endcase
      for (j = 0; j < burst && left > 0; j++) begin
        op = ($urandom_range(99) < enq_pct) ? prq_pkg::FUNC_ENQ : prq_pkg::FUNC_DEQ;
        send_item(op, pick_tag(), pick_prio());
        left--;
      end
    end
  endtask

  // Random traffic under three idling patterns
  task automatic test_random_traffic();
    send_idle_pct = 29;
    recv_idle_pct = 59;
    run_bursts(150);
    send_idle_pct = 59;
    recv_idle_pct = 29;
    run_bursts(150);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_bursts(150);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_basic_order();
    test_full_queue();
    test_random_traffic();
    in_valid <= 1'b0;
    // Drain outstanding results, then let the block settle
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
